// ===== hdl/tpa_pkg.sv =====
// ---------------------------------------------------------------------------
// tpa_pkg: shared types and constants for the three-point arc fit
// Widths of the wide datapath, CORDIC angle table and the sideband structs
// that travel down the pipeline next to each item.
// ---------------------------------------------------------------------------
package tpa_pkg;

   // numerator of the center offset, signed
   localparam int NW = 100;
   // divider remainder and divisor widths
   localparam int RW = 102;
   localparam int DW = 68;
   // |det| width
   localparam int AW = 66;
   // quotient bits kept; anything at or above 2^QB saturates the center anyway
   localparam int QB = 34;
   // square root iterations for a 64-bit radicand
   localparam int SQ_STEPS = 32;
   // deepest CORDIC supported
   localparam int ATAN_DEPTH = 40;

   localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
   localparam logic [30:0] RADIUS_MAX = 31'h7FFF_FFFF;

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [31:0] ATAN_TURNS [ATAN_DEPTH] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
      32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
      32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
      32'd20, 32'd10, 32'd5, 32'd3, 32'd1,
      32'd1, 32'd0, 32'd0, 32'd0, 32'd0,
      32'd0, 32'd0, 32'd0, 32'd0, 32'd0
   };

   // points and flags carried through the front end and divider
   typedef struct packed {
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] zmid;
      logic               ccw;
      logic               colin;
   } pt_type;

   // one divider lane: magnitudes and result sign
   typedef struct packed {
      logic [RW-1:0] num;
      logic [DW-1:0] den;
      logic          neg;
   } lane_type;

   // item after the center is known
   typedef struct packed {
      pt_type             pt;
      logic signed [31:0] rx;
      logic signed [31:0] ry;
   } cen_type;

   // center plus the start and end vectors seen from it
   typedef struct packed {
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [31:0] zmid;
      logic               ccw;
      logic               colin;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] ex;
      logic signed [32:0] ey;
   } geo_type;

   // geometry plus radius
   typedef struct packed {
      geo_type     geo;
      logic [30:0] radius;
   } rad_type;

   // everything the sweep stage needs
   typedef struct packed {
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [31:0] zmid;
      logic               ccw;
      logic               colin;
      logic [30:0]        radius;
      logic [31:0]        ts;
      logic [31:0]        te;
   } arc_type;

endpackage

// ===== hdl/three_point_arc_fit.sv =====
// ---------------------------------------------------------------------------
// three_point_arc_fit: circular arc through three points
// Center, direction, radius and sweep of the arc through start, middle and
// end points given in Q16.16.
//
//   channel  ports   handshake          payload
//   input    req_*   req_valid/stall    start, mid, end points (x, y, z)
//   output   rsp_*   rsp_valid/stall    center xyz, direction, sweep, radius
//
// One item enters per cycle while the output is not stalled. Depth is set by
// the 34-bit-quotient divider, the 32-step square root and the CORDIC lanes,
// each one bit or one rotation per stage.
// Reset clears only the valid bits; there is no clearing pass.
// A stalled output holds the whole pipeline; no item is lost or repeated.
// mid_z has no effect on the result.
// ---------------------------------------------------------------------------
module three_point_arc_fit #(
   parameter int CORDIC_STEPS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_start_z,
   input  logic signed [31:0] req_mid_x,
   input  logic signed [31:0] req_mid_y,
   input  logic signed [31:0] req_mid_z,
   input  logic signed [31:0] req_end_x,
   input  logic signed [31:0] req_end_y,
   input  logic signed [31:0] req_end_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_center_x,
   output logic signed [31:0] rsp_center_y,
   output logic signed [31:0] rsp_center_z,
   output logic               rsp_counterclockwise,
   output logic [31:0]        rsp_sweep,
   output logic [30:0]        rsp_radius,
   output logic               rsp_collinear
);
   import tpa_pkg::*;

   logic     adv;
   logic     fr_valid, dv_valid, sq_valid, cd_valid;
   lane_type lane_x, lane_y;
   pt_type   pt;
   cen_type  cen;
   rad_type  rad;
   arc_type  arc;

   logic        t1_vld_ff;
   arc_type     t1_arc_ff;
   logic        t1_dz_ff;
   logic [63:0] t1_m_ff;
   logic [31:0] d_turn;
   logic [63:0] m_round;

   logic               out_vld_ff;
   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic               ccw_ff, colin_ff;
   logic [31:0]        sweep_ff;
   logic [30:0]        radius_ff;

   // whole pipeline moves unless a finished item is held
   assign adv       = ~out_vld_ff | ~rsp_stall;
   assign req_stall = ~adv;

   tpa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .start_x   (req_start_x),
      .start_y   (req_start_y),
      .start_z   (req_start_z),
      .mid_x     (req_mid_x),
      .mid_y     (req_mid_y),
      .end_x     (req_end_x),
      .end_y     (req_end_y),
      .end_z     (req_end_z),
      .out_valid (fr_valid),
      .lane_x    (lane_x),
      .lane_y    (lane_y),
      .pt        (pt)
   );

   tpa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .lane_x    (lane_x),
      .lane_y    (lane_y),
      .pt        (pt),
      .out_valid (dv_valid),
      .cen       (cen)
   );

   tpa_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (dv_valid),
      .cen       (cen),
      .out_valid (sq_valid),
      .rad       (rad)
   );

   tpa_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .rad       (rad),
      .out_valid (cd_valid),
      .arc       (arc)
   );

   // heading difference in the arc's direction
   assign d_turn  = arc.ccw ? (arc.te - arc.ts) : (arc.ts - arc.te);
   assign m_round = t1_m_ff + 64'h8000_0000;

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         t1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         t1_vld_ff  <= cd_valid;
         out_vld_ff <= t1_vld_ff;
      end
   end

   // scale turns to radians, then clear the arc fields of collinear items
   always_ff @(posedge clock) begin
      if (adv) begin
         t1_arc_ff <= arc;
         t1_dz_ff  <= (d_turn == '0);
         t1_m_ff   <= {32'd0, d_turn} * {32'd0, TWO_PI_Q29};
         cz_ff     <= t1_arc_ff.zmid;
         colin_ff  <= t1_arc_ff.colin;
         if (t1_arc_ff.colin) begin
            cx_ff     <= '0;
            cy_ff     <= '0;
            ccw_ff    <= 1'b0;
            sweep_ff  <= '0;
            radius_ff <= '0;
         end else begin
            cx_ff     <= t1_arc_ff.rx;
            cy_ff     <= t1_arc_ff.ry;
            ccw_ff    <= t1_arc_ff.ccw;
            sweep_ff  <= t1_dz_ff ? TWO_PI_Q29 : m_round[63:32];
            radius_ff <= t1_arc_ff.radius;
         end
      end
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_center_x         = cx_ff;
   assign rsp_center_y         = cy_ff;
   assign rsp_center_z         = cz_ff;
   assign rsp_counterclockwise = ccw_ff;
   assign rsp_sweep            = sweep_ff;
   assign rsp_radius           = radius_ff;
   assign rsp_collinear        = colin_ff;

`ifndef SYNTHESIS
   // collinear items carry no arc
   a_colin_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_collinear |-> rsp_sweep == '0 && rsp_radius == '0
         && rsp_center_x == '0 && rsp_center_y == '0 && !rsp_counterclockwise)
      else $error("collinear item with nonzero arc fields");

   // a real arc never sweeps zero nor more than a full turn
   a_sweep_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_collinear |-> rsp_sweep != '0 && rsp_sweep <= TWO_PI_Q29)
      else $error("sweep out of range");

   // input is held exactly when a finished item waits
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output stall");
`endif

endmodule

// ===== hdl/tpa_front.sv =====
// ---------------------------------------------------------------------------
// tpa_front: orientation and circumcenter numerators
// Seven stages: chord vectors, products, determinant and squared lengths,
// split partial products, numerators, magnitudes, divider operands.
// ---------------------------------------------------------------------------
module tpa_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic signed [31:0] start_x,
   input  logic signed [31:0] start_y,
   input  logic signed [31:0] start_z,
   input  logic signed [31:0] mid_x,
   input  logic signed [31:0] mid_y,
   input  logic signed [31:0] end_x,
   input  logic signed [31:0] end_y,
   input  logic signed [31:0] end_z,
   output logic               out_valid,
   output tpa_pkg::lane_type  lane_x,
   output tpa_pkg::lane_type  lane_y,
   output tpa_pkg::pt_type    pt
);
   import tpa_pkg::*;

   logic [6:0] vld_ff;

   pt_type pt1_ff, pt2_ff, pt3_ff, pt4_ff, pt5_ff, pt6_ff, pt7_ff;
   pt_type pt1_in, pt4_in;

   logic signed [32:0] ux1_ff, uy1_ff, vx1_ff, vy1_ff;
   logic signed [32:0] ux2_ff, uy2_ff, vx2_ff, vy2_ff;
   logic signed [32:0] ux3_ff, uy3_ff, vx3_ff, vy3_ff;
   logic signed [65:0] puv2_ff, pvu2_ff, squx2_ff, squy2_ff, sqvx2_ff, sqvy2_ff;
   logic signed [66:0] det3_ff, det4_ff, det3_in;
   logic [64:0]        su3_ff, sv3_ff;
   logic signed [66:0] axl4_ff, bxl4_ff, ayl4_ff, byl4_ff;
   logic signed [65:0] axh4_ff, bxh4_ff, ayh4_ff, byh4_ff;
   logic signed [NW-1:0] nx5_ff, ny5_ff, nx5_in, ny5_in;
   logic [AW-1:0]      ad5_ff, ad6_ff;
   logic               dneg5_ff;
   logic [NW-2:0]      anx6_ff, any6_ff;
   logic               negx6_ff, negy6_ff;
   lane_type           lx7_ff, ly7_ff;
   logic signed [32:0] zsum;

   // advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[5:0], in_valid};
      end
   end

   // start and end points and z midpoint
   always_comb begin
      zsum          = $signed({start_z[31], start_z}) + $signed({end_z[31], end_z});
      pt1_in.ax     = start_x;
      pt1_in.ay     = start_y;
      pt1_in.cx     = end_x;
      pt1_in.cy     = end_y;
      pt1_in.zmid   = zsum[32:1];
      pt1_in.ccw    = 1'b0;
      pt1_in.colin  = 1'b0;
   end

   // determinant sign and zero test
   always_comb begin
      det3_in = det3_ff;
      pt4_in  = pt3_ff;
      pt4_in.colin = (det3_in == '0);
      pt4_in.ccw   = ~det3_in[66];
   end

   // numerators: su*vy - sv*uy and sv*ux - su*vx from split products
   always_comb begin
      nx5_in = ($signed({{(NW-66){axh4_ff[65]}}, axh4_ff}) <<< 33)
             + $signed({{(NW-67){axl4_ff[66]}}, axl4_ff})
             - ($signed({{(NW-66){bxh4_ff[65]}}, bxh4_ff}) <<< 33)
             - $signed({{(NW-67){bxl4_ff[66]}}, bxl4_ff});
      ny5_in = ($signed({{(NW-66){ayh4_ff[65]}}, ayh4_ff}) <<< 33)
             + $signed({{(NW-67){ayl4_ff[66]}}, ayl4_ff})
             - ($signed({{(NW-66){byh4_ff[65]}}, byh4_ff}) <<< 33)
             - $signed({{(NW-67){byl4_ff[66]}}, byl4_ff});
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 1
         ux1_ff <= $signed({mid_x[31], mid_x}) - $signed({start_x[31], start_x});
         uy1_ff <= $signed({mid_y[31], mid_y}) - $signed({start_y[31], start_y});
         vx1_ff <= $signed({end_x[31], end_x}) - $signed({start_x[31], start_x});
         vy1_ff <= $signed({end_y[31], end_y}) - $signed({start_y[31], start_y});
         pt1_ff <= pt1_in;
         // stage 2
         puv2_ff  <= ux1_ff * vy1_ff;
         pvu2_ff  <= uy1_ff * vx1_ff;
         squx2_ff <= ux1_ff * ux1_ff;
         squy2_ff <= uy1_ff * uy1_ff;
         sqvx2_ff <= vx1_ff * vx1_ff;
         sqvy2_ff <= vy1_ff * vy1_ff;
         ux2_ff <= ux1_ff;
         uy2_ff <= uy1_ff;
         vx2_ff <= vx1_ff;
         vy2_ff <= vy1_ff;
         pt2_ff <= pt1_ff;
         // stage 3
         det3_ff <= $signed({puv2_ff[65], puv2_ff}) - $signed({pvu2_ff[65], pvu2_ff});
         su3_ff  <= {1'b0, squx2_ff[63:0]} + {1'b0, squy2_ff[63:0]};
         sv3_ff  <= {1'b0, sqvx2_ff[63:0]} + {1'b0, sqvy2_ff[63:0]};
         ux3_ff <= ux2_ff;
         uy3_ff <= uy2_ff;
         vx3_ff <= vx2_ff;
         vy3_ff <= vy2_ff;
         pt3_ff <= pt2_ff;
         // stage 4
         axl4_ff <= $signed({1'b0, su3_ff[32:0]}) * vy3_ff;
         axh4_ff <= $signed({1'b0, su3_ff[64:33]}) * vy3_ff;
         bxl4_ff <= $signed({1'b0, sv3_ff[32:0]}) * uy3_ff;
         bxh4_ff <= $signed({1'b0, sv3_ff[64:33]}) * uy3_ff;
         ayl4_ff <= $signed({1'b0, sv3_ff[32:0]}) * ux3_ff;
         ayh4_ff <= $signed({1'b0, sv3_ff[64:33]}) * ux3_ff;
         byl4_ff <= $signed({1'b0, su3_ff[32:0]}) * vx3_ff;
         byh4_ff <= $signed({1'b0, su3_ff[64:33]}) * vx3_ff;
         det4_ff <= det3_ff;
         pt4_ff  <= pt4_in;
         // stage 5
         nx5_ff   <= nx5_in;
         ny5_ff   <= ny5_in;
         ad5_ff   <= det4_ff[66] ? AW'(-det4_ff) : det4_ff[AW-1:0];
         dneg5_ff <= det4_ff[66];
         pt5_ff   <= pt4_ff;
         // stage 6
         anx6_ff  <= nx5_ff[NW-1] ? (NW-1)'(-nx5_ff) : nx5_ff[NW-2:0];
         any6_ff  <= ny5_ff[NW-1] ? (NW-1)'(-ny5_ff) : ny5_ff[NW-2:0];
         negx6_ff <= nx5_ff[NW-1] ^ dneg5_ff;
         negy6_ff <= ny5_ff[NW-1] ^ dneg5_ff;
         ad6_ff   <= ad5_ff;
         pt6_ff   <= pt5_ff;
         // stage 7: rounded quotient operands (2|n| + |2det|) / (2|2det|)
         lx7_ff.num <= RW'({anx6_ff, 1'b0}) + RW'({ad6_ff, 1'b0});
         lx7_ff.den <= {ad6_ff, 2'b00};
         lx7_ff.neg <= negx6_ff;
         ly7_ff.num <= RW'({any6_ff, 1'b0}) + RW'({ad6_ff, 1'b0});
         ly7_ff.den <= {ad6_ff, 2'b00};
         ly7_ff.neg <= negy6_ff;
         pt7_ff <= pt6_ff;
      end
   end

   assign out_valid = vld_ff[6];
   assign lane_x    = lx7_ff;
   assign lane_y    = ly7_ff;
   assign pt        = pt7_ff;

endmodule

// ===== hdl/tpa_div.sv =====
// ---------------------------------------------------------------------------
// tpa_div: pipelined restoring divider for both center axes
// An overflow test, one quotient bit per stage, then sign and saturating
// add of the start point.
// ---------------------------------------------------------------------------
module tpa_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  tpa_pkg::lane_type lane_x,
   input  tpa_pkg::lane_type lane_y,
   input  tpa_pkg::pt_type   pt,
   output logic              out_valid,
   output tpa_pkg::cen_type  cen
);
   import tpa_pkg::*;

   typedef struct packed {
      logic [RW-1:0] rem;
      logic [DW-1:0] den;
      logic [QB-1:0] quo;
      logic          ovf;
      logic          neg;
   } dst_type;

   dst_type    sx_ff [QB+1];
   dst_type    sy_ff [QB+1];
   pt_type     pt_ff [QB+1];
   logic [QB:0] vld_ff;
   logic       out_vld_ff;
   cen_type    cen_ff;

   function automatic dst_type div_init(lane_type l);
      dst_type r;
      r.rem = l.num;
      r.den = l.den;
      r.quo = '0;
      r.ovf = (l.num >= (RW'(l.den) << QB));
      r.neg = l.neg;
      return r;
   endfunction

   function automatic dst_type div_step(dst_type s, int unsigned b);
      dst_type       r;
      logic [RW-1:0] t;
      r = s;
      t = RW'(s.den) << b;
      if (s.rem >= t) begin
         r.rem = s.rem - t;
         r.quo = s.quo | (QB'(1) << b);
      end
      return r;
   endfunction

   // signed quotient plus base, saturated to 32 bits
   function automatic logic signed [31:0] place(dst_type s, logic signed [31:0] base);
      logic [QB:0]          qm;
      logic signed [QB+1:0] qs;
      logic signed [QB+2:0] sum;
      logic signed [31:0]   r;
      qm  = s.ovf ? ((QB+1)'(1) << QB) : {1'b0, s.quo};
      qs  = s.neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
      sum = qs + base;
      if (sum[QB+2:31] == '0 || sum[QB+2:31] == '1) begin
         r = sum[31:0];
      end else begin
         r = sum[QB+2] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[QB-1:0], in_valid};
         out_vld_ff <= vld_ff[QB];
      end
   end

   // overflow test stage
   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff[0] <= div_init(lane_x);
         sy_ff[0] <= div_init(lane_y);
         pt_ff[0] <= pt;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar s = 1; s <= QB; s++) begin : g_step
      always_ff @(posedge clock) begin
         if (adv) begin
            sx_ff[s] <= div_step(sx_ff[s-1], QB - s);
            sy_ff[s] <= div_step(sy_ff[s-1], QB - s);
            pt_ff[s] <= pt_ff[s-1];
         end
      end
   end

   // center from start point and signed offset
   always_ff @(posedge clock) begin
      if (adv) begin
         cen_ff.pt <= pt_ff[QB];
         cen_ff.rx <= place(sx_ff[QB], pt_ff[QB].ax);
         cen_ff.ry <= place(sy_ff[QB], pt_ff[QB].ay);
      end
   end

   assign out_valid = out_vld_ff;
   assign cen       = cen_ff;

endmodule

// ===== hdl/tpa_isqrt.sv =====
// ---------------------------------------------------------------------------
// tpa_isqrt: radius from start point to center
// Vectors from the center, squares, then a 32-stage digit-by-digit square
// root with round to nearest and saturation.
// ---------------------------------------------------------------------------
module tpa_isqrt (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  tpa_pkg::cen_type cen,
   output logic             out_valid,
   output tpa_pkg::rad_type rad
);
   import tpa_pkg::*;

   typedef struct packed {
      logic [63:0] s;
      logic [63:0] res;
   } qst_type;

   geo_type            geo0_ff, geo1_ff, geo0_in;
   logic               big0_ff, big1_ff;
   logic signed [63:0] sqx1_ff, sqy1_ff;
   qst_type            q_ff   [SQ_STEPS+1];
   geo_type            geo_ff [SQ_STEPS+1];
   logic               big_ff [SQ_STEPS+1];
   logic [SQ_STEPS+3:0] vld_ff;
   rad_type            rad_ff;
   logic [33:0]        rr;

   function automatic qst_type sq_step(qst_type q, int unsigned k);
      qst_type     r;
      logic [63:0] bit_v;
      logic [63:0] t;
      bit_v = 64'd1 << (62 - 2 * k);
      t     = q.res + bit_v;
      if (q.s >= t) begin
         r.s   = q.s - t;
         r.res = (q.res >> 1) + bit_v;
      end else begin
         r.s   = q.s;
         r.res = q.res >> 1;
      end
      return r;
   endfunction

   // vectors from the center to start and end
   always_comb begin
      geo0_in.rx    = cen.rx;
      geo0_in.ry    = cen.ry;
      geo0_in.zmid  = cen.pt.zmid;
      geo0_in.ccw   = cen.pt.ccw;
      geo0_in.colin = cen.pt.colin;
      geo0_in.dx    = $signed({cen.pt.ax[31], cen.pt.ax}) - $signed({cen.rx[31], cen.rx});
      geo0_in.dy    = $signed({cen.pt.ay[31], cen.pt.ay}) - $signed({cen.ry[31], cen.ry});
      geo0_in.ex    = $signed({cen.pt.cx[31], cen.pt.cx}) - $signed({cen.rx[31], cen.rx});
      geo0_in.ey    = $signed({cen.pt.cy[31], cen.pt.cy}) - $signed({cen.ry[31], cen.ry});
   end

   // rounded root of the last stage
   always_comb begin
      rr = {1'b0, q_ff[SQ_STEPS].res[32:0]};
      if (q_ff[SQ_STEPS].s > q_ff[SQ_STEPS].res) begin
         rr = rr + 34'd1;
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[SQ_STEPS+2:0], in_valid};
      end
   end

   // front: vectors, magnitude test, squares, sum
   always_ff @(posedge clock) begin
      if (adv) begin
         geo0_ff <= geo0_in;
         big0_ff <= (geo0_in.dx[32] != geo0_in.dx[31]) || (geo0_in.dx == {2'b11, 31'd0})
                 || (geo0_in.dy[32] != geo0_in.dy[31]) || (geo0_in.dy == {2'b11, 31'd0});
         sqx1_ff <= $signed(geo0_ff.dx[31:0]) * $signed(geo0_ff.dx[31:0]);
         sqy1_ff <= $signed(geo0_ff.dy[31:0]) * $signed(geo0_ff.dy[31:0]);
         geo1_ff <= geo0_ff;
         big1_ff <= big0_ff;
         q_ff[0].s   <= sqx1_ff + sqy1_ff;
         q_ff[0].res <= '0;
         geo_ff[0]   <= geo1_ff;
         big_ff[0]   <= big1_ff;
      end
   end

   // one root bit per stage
   for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_root
      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff[k]   <= sq_step(q_ff[k-1], k - 1);
            geo_ff[k] <= geo_ff[k-1];
            big_ff[k] <= big_ff[k-1];
         end
      end
   end

   // round and saturate
   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff.geo    <= geo_ff[SQ_STEPS];
         rad_ff.radius <= (big_ff[SQ_STEPS] || rr > 34'd2147483647) ? RADIUS_MAX : rr[30:0];
      end
   end

   assign out_valid = vld_ff[SQ_STEPS+3];
   assign rad       = rad_ff;

endmodule

// ===== hdl/tpa_cordic.sv =====
// ---------------------------------------------------------------------------
// tpa_cordic: headings of the start and end vectors
// Two vectoring CORDIC lanes side by side, one rotation per stage, angle in
// binary turns.
// ---------------------------------------------------------------------------
module tpa_cordic #(
   parameter int STEPS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  tpa_pkg::rad_type rad,
   output logic             out_valid,
   output tpa_pkg::arc_type arc
);
   import tpa_pkg::*;

   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic [31:0]        z;
      logic               zero;
   } cst_type;

   cst_type    cs_ff [STEPS+1];
   cst_type    ce_ff [STEPS+1];
   rad_type    rad_ff [STEPS+1];
   logic [STEPS:0] vld_ff;

   // fold into the right half plane and prescale
   function automatic cst_type cd_init(logic signed [32:0] vx, logic signed [32:0] vy);
      cst_type            c;
      logic signed [63:0] x;
      logic signed [63:0] y;
      x      = $signed({{31{vx[32]}}, vx});
      y      = $signed({{31{vy[32]}}, vy});
      c.zero = (vx == '0) && (vy == '0);
      c.z    = '0;
      if (x < 0) begin
         x   = -x;
         y   = -y;
         c.z = 32'h8000_0000;
      end
      c.x = x <<< 20;
      c.y = y <<< 20;
      return c;
   endfunction

   // rotate toward the x axis
   function automatic cst_type cd_step(cst_type c, int unsigned i, logic [31:0] ang);
      cst_type            r;
      logic signed [63:0] dxs;
      logic signed [63:0] dys;
      r   = c;
      dxs = c.y >>> i;
      dys = c.x >>> i;
      if (c.y > 0) begin
         r.x = c.x + dxs;
         r.y = c.y - dys;
         r.z = c.z + ang;
      end else begin
         r.x = c.x - dxs;
         r.y = c.y + dys;
         r.z = c.z - ang;
      end
      return r;
   endfunction

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[STEPS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cs_ff[0]  <= cd_init(rad.geo.dx, rad.geo.dy);
         ce_ff[0]  <= cd_init(rad.geo.ex, rad.geo.ey);
         rad_ff[0] <= rad;
      end
   end

   for (genvar s = 1; s <= STEPS; s++) begin : g_rot
      always_ff @(posedge clock) begin
         if (adv) begin
            cs_ff[s]  <= cd_step(cs_ff[s-1], s - 1, ATAN_TURNS[s-1]);
            ce_ff[s]  <= cd_step(ce_ff[s-1], s - 1, ATAN_TURNS[s-1]);
            rad_ff[s] <= rad_ff[s-1];
         end
      end
   end

   // a zero vector has heading zero
   always_comb begin
      arc.rx     = rad_ff[STEPS].geo.rx;
      arc.ry     = rad_ff[STEPS].geo.ry;
      arc.zmid   = rad_ff[STEPS].geo.zmid;
      arc.ccw    = rad_ff[STEPS].geo.ccw;
      arc.colin  = rad_ff[STEPS].geo.colin;
      arc.radius = rad_ff[STEPS].radius;
      arc.ts     = cs_ff[STEPS].zero ? 32'd0 : cs_ff[STEPS].z;
      arc.te     = ce_ff[STEPS].zero ? 32'd0 : ce_ff[STEPS].z;
   end

   assign out_valid = vld_ff[STEPS];

endmodule

// ===== tb/tb_arc_fit_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_arc_fit_checker: arc fit predictor and result scoreboard
// Watches both channels of the three-point arc fit. Each accepted item is run
// through an exact integer circumcenter, radius and CORDIC sweep prediction;
// each accepted result is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_arc_fit_checker #(
   parameter int CORDIC_STEPS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_start_z,
   input  logic signed [31:0] req_mid_x,
   input  logic signed [31:0] req_mid_y,
   input  logic signed [31:0] req_end_x,
   input  logic signed [31:0] req_end_y,
   input  logic signed [31:0] req_end_z,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_center_x,
   input  logic signed [31:0] rsp_center_y,
   input  logic signed [31:0] rsp_center_z,
   input  logic               rsp_counterclockwise,
   input  logic [31:0]        rsp_sweep,
   input  logic [30:0]        rsp_radius,
   input  logic               rsp_collinear,
   output int                 fail_count,
   output int                 pending_count
);
   import tpa_pkg::*;

   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic               ccw;
      logic [31:0]        sweep;
      logic [30:0]        radius;
      logic               colin;
   } arc_result_type;

   arc_result_type arc_fifo[$];

   // rounded n/d, ties away from zero, clamped to +-2^40
   function automatic longint div_nearest(logic signed [127:0] n, logic signed [127:0] d);
      logic [127:0] an, ad, q;
      logic         neg;
      neg = n[127] ^ d[127];
      an = n[127] ? -n : n;
      ad = d[127] ? -d : d;
      q = (2 * an + ad) / (2 * ad);
      if (q > 128'd1099511627776) q = 128'd1099511627776;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // CORDIC heading in binary turns
   function automatic logic [31:0] heading_turns(longint x, longint y);
      logic [31:0] z;
      longint      sx, sy;
      z = 0;
      if (x == 0 && y == 0) return 32'd0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32'h8000_0000;
      end
      x = x * 1048576;
      y = y * 1048576;
      for (int i = 0; i < CORDIC_STEPS && i < ATAN_DEPTH; i++) begin
         sx = y >>> i;
         sy = x >>> i;
         if (y > 0) begin
            x += sx;
            y -= sy;
            z += ATAN_TURNS[i];
         end else begin
            x -= sx;
            y += sy;
            z -= ATAN_TURNS[i];
         end
      end
      return z;
   endfunction

   function automatic arc_result_type fit_arc(longint ax, longint ay, longint az, longint bx,
                                              longint by, longint ex, longint ey, longint ez);
      arc_result_type      r;
      logic signed [127:0] det, su, sv, nx, ny;
      longint             ux, uy, vx, vy, rx, ry, dx, dy;
      logic [63:0]        s, rt;
      logic [31:0]        ts, te, d;
      logic [63:0]        prod;
      r = '0;
      ux = bx - ax;
      uy = by - ay;
      vx = ex - ax;
      vy = ey - ay;
      r.cz = 32'((az + ez) >>> 1);
      det = 128'(ux) * 128'(vy) - 128'(uy) * 128'(vx);
      if (det == 0) begin
         r.colin = 1'b1;
         return r;
      end
      r.ccw = !det[127];
      su = 128'(ux) * 128'(ux) + 128'(uy) * 128'(uy);
      sv = 128'(vx) * 128'(vx) + 128'(vy) * 128'(vy);
      nx = su * 128'(vy) - sv * 128'(uy);
      ny = sv * 128'(ux) - su * 128'(vx);
      rx = clamp32(ax + div_nearest(nx, 2 * det));
      ry = clamp32(ay + div_nearest(ny, 2 * det));
      r.cx = 32'(rx);
      r.cy = 32'(ry);
      dx = ax - rx;
      dy = ay - ry;
      if (dx >= 64'sd2147483648 || dx <= -64'sd2147483648 ||
          dy >= 64'sd2147483648 || dy <= -64'sd2147483648) begin
         r.radius = RADIUS_MAX;
      end else begin
         s = dx * dx + dy * dy;
         rt = 0;
         // bitwise integer root
         for (int b = 31; b >= 0; b--)
            if ((rt | (64'd1 << b)) * (rt | (64'd1 << b)) <= s) rt |= 64'd1 << b;
         if (s - rt * rt > rt) rt++;
         r.radius = rt > 64'd2147483647 ? RADIUS_MAX : rt[30:0];
      end
      ts = heading_turns(dx, dy);
      te = heading_turns(ex - rx, ey - ry);
      d = r.ccw ? te - ts : ts - te;
      if (d == 0) begin
         r.sweep = TWO_PI_Q29;
      end else begin
         prod = 64'(d) * 64'(TWO_PI_Q29) + 64'h8000_0000;
         r.sweep = prod[63:32];
      end
      return r;
   endfunction

   assign pending_count = arc_fifo.size();

   // predict on accepted items, compare on accepted results
   always @(posedge clock) begin
      arc_result_type want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            arc_fifo.push_back(fit_arc(req_start_x, req_start_y, req_start_z, req_mid_x,
                                       req_mid_y, req_end_x, req_end_y, req_end_z));
         if (rsp_valid && !rsp_stall) begin
            if (arc_fifo.size() == 0) begin
               $error("result with no item pending");
               fail_count <= fail_count + 1;
            end else begin
               want = arc_fifo.pop_front();
               if (rsp_center_x !== want.cx || rsp_center_y !== want.cy ||
                   rsp_center_z !== want.cz || rsp_counterclockwise !== want.ccw ||
                   rsp_sweep !== want.sweep || rsp_radius !== want.radius ||
                   rsp_collinear !== want.colin)
                  fail_count <= fail_count + 1;
               if (rsp_center_x !== want.cx)
                  $error("center_x expected %0d got %0d", want.cx, rsp_center_x);
               if (rsp_center_y !== want.cy)
                  $error("center_y expected %0d got %0d", want.cy, rsp_center_y);
               if (rsp_center_z !== want.cz)
                  $error("center_z expected %0d got %0d", want.cz, rsp_center_z);
               if (rsp_counterclockwise !== want.ccw)
                  $error("counterclockwise expected %0b got %0b", want.ccw,
                         rsp_counterclockwise);
               if (rsp_sweep !== want.sweep)
                  $error("sweep expected %0d got %0d", want.sweep, rsp_sweep);
               if (rsp_radius !== want.radius)
                  $error("radius expected %0d got %0d", want.radius, rsp_radius);
               if (rsp_collinear !== want.colin)
                  $error("collinear expected %0b got %0b", want.colin, rsp_collinear);
            end
         end
      end
   end

endmodule

// ===== tb/tb_three_point_arc_fit.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_three_point_arc_fit: top of the arc fit testbench
// Drives directed corner arcs then random well-formed and extreme arcs under
// three idle patterns on both channels; the checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_three_point_arc_fit;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_start_x = 0, req_start_y = 0, req_start_z = 0;
   logic signed [31:0] req_mid_x = 0, req_mid_y = 0, req_mid_z = 0;
   logic signed [31:0] req_end_x = 0, req_end_y = 0, req_end_z = 0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_center_x, rsp_center_y, rsp_center_z;
   logic               rsp_counterclockwise;
   logic [31:0]        rsp_sweep;
   logic [30:0]        rsp_radius;
   logic               rsp_collinear;
   int                 fail_count;
   int                 pending_count;
   int                 send_idle_pct = 37;
   int                 recv_idle_pct = 60;

   localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MINV = 32'sh8000_0000;

   always #10 clock = ~clock;

   three_point_arc_fit u_dut (.*);

   tb_arc_fit_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_start_x, .req_start_y, .req_start_z,
      .req_mid_x, .req_mid_y, .req_end_x, .req_end_y, .req_end_z, .rsp_valid, .rsp_stall,
      .rsp_center_x, .rsp_center_y, .rsp_center_z, .rsp_counterclockwise, .rsp_sweep,
      .rsp_radius, .rsp_collinear, .fail_count, .pending_count
   );

   // receiver stall pattern
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   // offer one item, idle at random first, hold until accepted
   task automatic send_arc(logic signed [31:0] sx, sy, sz, mx, my, mz, ex, ey, ez);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_x <= sx; req_start_y <= sy; req_start_z <= sz;
      req_mid_x <= mx;   req_mid_y <= my;   req_mid_z <= mz;
      req_end_x <= ex;   req_end_y <= ey;   req_end_z <= ez;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // random arc: points on a circle of random center and size, collinear or extreme points, or raw noise
   task automatic send_random_arc();
      logic signed [31:0] p[9];
      int                 kind, cxr, cyr, rr;
      real                a;
      kind = $urandom_range(9);
      foreach (p[i]) p[i] = $urandom;
      if (kind < 6) begin
         cxr = $signed($urandom) >>> $urandom_range(31, 4);
         cyr = $signed($urandom) >>> $urandom_range(31, 4);
         rr = $urandom_range(32'h3FFF_FFFF >> $urandom_range(30, 0), 1);
         for (int k = 0; k < 3; k++) begin
            a = $urandom_range(62831) / 10000.0;
            p[3 * k] = cxr + int'(rr * $cos(a)) / 2;
            p[3 * k + 1] = cyr + int'(rr * $sin(a)) / 2;
         end
      end else if (kind == 6) begin
         // collinear, sometimes coincident
         p[3] = p[0] + (p[6] - p[0]) / 2;
         p[4] = p[1] + (p[7] - p[1]) / 2;
         if ($urandom_range(1)) begin
            p[3] = p[0]; p[4] = p[1];
         end
      end else if (kind == 7) begin
         foreach (p[i]) p[i] = $urandom_range(1) ? MAXV - $urandom_range(3)
                                                 : MINV + $urandom_range(3);
      end
      send_arc(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: simple ccw/cw, vertical chord, collinear, coincident, extremes
      send_arc(32'h10000, 0, 0, 0, 32'h10000, 32'h5, -32'h10000, 0, 32'h30000);
      send_arc(-32'h10000, 0, -1, 0, 32'h10000, 0, 32'h10000, 0, 0);
      send_arc(0, 0, 0, 32'h10000, 32'h10000, 0, 0, 32'h20000, 0);
      send_arc(0, 0, 0, 32'h10000, 32'h10000, 0, 32'h20000, 32'h20000, 0);
      send_arc(5, 5, MAXV, 5, 5, 0, 5, 5, MAXV);
      send_arc(MINV, MINV, MINV, MAXV, MINV, MAXV, MAXV, MAXV, MINV);
      send_arc(MAXV, MAXV, MAXV, MINV, MAXV, MINV, MINV, MINV, MAXV);
      send_arc(0, 0, 0, 1, 0, 0, 0, 1, 0);
      send_arc(0, 0, 0, 1, 1, 0, 2, 0, 0);
      send_arc(0, 0, 0, 1000, 1, 0, 2000, 0, 0);
      send_arc(0, 0, 0, 1, MAXV, 0, 2, 0, 0);
      send_arc(MINV, 0, 0, 0, 1, 0, MAXV, 0, 0);
      send_arc(32'h10000, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0);
      send_arc(0, MINV, -1, MAXV, 0, -1, 0, MAXV, -2);
      for (int i = 0; i < 1540; i++) begin
         if (i == 520) begin
            send_idle_pct = 60;
            recv_idle_pct = 37;
         end else if (i == 1040) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_random_arc();
      end
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // run limit
   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

endmodule
